FILE: rtl/query_language_lexer_core_macros.svh
// assertion macros for the query language lexer
`ifndef QUERY_LANGUAGE_LEXER_CORE_MACROS_SVH
`define QUERY_LANGUAGE_LEXER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QLL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QLL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QLL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define QLL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/qll_pkg.sv
// shared types and constants of the query language lexer
`default_nettype none
package qll_pkg;
    localparam int unsigned KIND_BITS = 6;
    localparam int unsigned LINE_BITS = 24;

    localparam logic [5:0] K_WS       = 6'd0;
    localparam logic [5:0] K_EOF      = 6'd1;
    localparam logic [5:0] K_LCOMMENT = 6'd2;
    localparam logic [5:0] K_ERROR    = 6'd3;
    localparam logic [5:0] K_BCOMMENT = 6'd4;
    localparam logic [5:0] K_SLASH    = 6'd5;
    localparam logic [5:0] K_QNAME    = 6'd6;
    localparam logic [5:0] K_STRING   = 6'd7;
    localparam logic [5:0] K_INT      = 6'd8;
    localparam logic [5:0] K_KW0      = 6'd9;
    localparam logic [5:0] K_TYPE     = 6'd25;
    localparam logic [5:0] K_NAME     = 6'd26;
    localparam logic [5:0] K_QUESTION = 6'd39;
    localparam logic [5:0] K_NE       = 6'd43;
    localparam logic [5:0] K_NOT      = 6'd44;
    localparam logic [5:0] K_LE       = 6'd45;
    localparam logic [5:0] K_LT       = 6'd46;
    localparam logic [5:0] K_GE       = 6'd47;
    localparam logic [5:0] K_GT       = 6'd48;

    localparam logic [0:0] REG_FIRST_LINE   = 1'b0;
    localparam logic [0:0] REG_FIRST_COLUMN = 1'b1;

    typedef enum logic [3:0] {
        MD_IDLE, MD_WS, MD_LCOMMENT, MD_SLASH, MD_BLOCK, MD_BLOCK_STAR,
        MD_QNAME, MD_QNAME_ESC, MD_STRING, MD_STRING_QUOTE, MD_INT, MD_WORD,
        MD_BANG, MD_LESS, MD_GREATER
    } t_mode;

    typedef struct packed {
        logic [5:0] kind;
        logic       start_cur;
        logic       end_next;
    } t_tok;

    // keyword spelled as 11 bytes, index 0 first
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
        logic [87:0] s;
        logic [7:0]  res;
        case (k)
            4'd0:  s = {"AS", 72'd0};
            4'd1:  s = {"BY", 72'd0};
            4'd2:  s = "CONSECUTIVE";
            4'd3:  s = {"DISTINCT", 24'd0};
            4'd4:  s = {"EXPORT", 40'd0};
            4'd5:  s = {"FROM", 56'd0};
            4'd6:  s = {"GROUP", 48'd0};
            4'd7:  s = {"IMPORT", 40'd0};
            4'd8:  s = {"JOIN", 56'd0};
            4'd9:  s = {"ON", 72'd0};
            4'd10: s = {"SELECT", 40'd0};
            4'd11: s = {"TO", 72'd0};
            4'd12: s = {"UPDATE", 40'd0};
            4'd13: s = {"USING", 48'd0};
            4'd14: s = {"WHERE", 48'd0};
            default: s = {"WITH", 56'd0};
        endcase
        res = 8'd0;
        if (p < 4'd11) res = s[8'd87 - 8'(p) * 8'd8 -: 8];
        return res;
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        logic [3:0] l;
        case (k)
            4'd0, 4'd1, 4'd9, 4'd11: l = 4'd2;
            4'd2:                    l = 4'd11;
            4'd3:                    l = 4'd8;
            4'd5, 4'd8, 4'd15:       l = 4'd4;
            4'd6, 4'd13, 4'd14:      l = 4'd5;
            default:                 l = 4'd6;
        endcase
        return l;
    endfunction

    // kind of a one-byte operator, K_ERROR when none
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h3B: k = 6'd27;
            8'h2C: k = 6'd28;
            8'h2E: k = 6'd29;
            8'h28: k = 6'd30;
            8'h29: k = 6'd31;
            8'h7B: k = 6'd32;
            8'h7D: k = 6'd33;
            8'h5B: k = 6'd34;
            8'h5D: k = 6'd35;
            8'h40: k = 6'd36;
            8'h23: k = 6'd37;
            8'h7E: k = 6'd38;
            8'h3F: k = K_QUESTION;
            8'h3A: k = 6'd40;
            8'h24: k = 6'd41;
            8'h3D: k = 6'd42;
            8'h2D: k = 6'd49;
            8'h2B: k = 6'd50;
            8'h2A: k = 6'd51;
            8'h5E: k = 6'd52;
            8'h25: k = 6'd53;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/qll_stream_if.sv
// valid/ready channel interfaces of the lexer
`default_nettype none
interface qll_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface qll_token_if #(parameter int OFFSET_BITS = 24, parameter int COLUMN_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [5:0]             token_kind;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] start_line;
    logic [COLUMN_BITS-1:0] start_column;
    logic [OFFSET_BITS-1:0] end_offset;
    logic [OFFSET_BITS-1:0] end_line;
    logic [COLUMN_BITS-1:0] end_column;
    logic                   last_of_run;
    modport source (output valid, output token_kind, output start_offset, output start_line,
        output start_column, output end_offset, output end_line, output end_column,
        output last_of_run, input ready);
    modport sink (input valid, input token_kind, input start_offset, input start_line,
        input start_column, input end_offset, input end_line, input end_column,
        input last_of_run, output ready);
endinterface

interface qll_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/query_language_lexer_core.sv
// query language lexer: one text byte in, up to two tokens out
//
// i_text is the byte channel, o_token the token channel, i_cfg the register
// write channel (index 0 first_line, 1 first_column). A byte is taken on
// valid and ready. Each byte is decoded combinationally into up to two
// tokens that sit in a three-entry output buffer; the second token of a
// byte goes out after the first. A byte is accepted while the buffer holds
// at most one token after this cycle's pop, so with a receiver that takes
// a token every cycle a byte is accepted every cycle: a byte that makes two
// tokens always leaves the lexer idle, and the next byte then makes at most
// one. The byte 0 ends the text: a pending token closes (ERROR if
// unterminated), END_OF_FILE follows and positions reload from the
// registers. Reset returns to the idle state, first_line and first_column
// to 1, and empties the buffer. A stalled receiver holds the token steady
// and backs up into the byte channel once the buffer holds two tokens.
`default_nettype none
`include "query_language_lexer_core_macros.svh"
module query_language_lexer_core #(
    parameter int OFFSET_BITS = 24,
    parameter int COLUMN_BITS = 16
) (
    input  wire i_clk,
    input  wire i_rst_n,
    qll_byte_if.sink    i_text,
    qll_cfg_if.sink     i_cfg,
    qll_token_if.source o_token
);
    import qll_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

    typedef struct packed {
        logic [5:0]             kind;
        logic [OFFSET_BITS-1:0] so, sl;
        logic [COLUMN_BITS-1:0] sc;
        logic [OFFSET_BITS-1:0] eo, el;
        logic [COLUMN_BITS-1:0] ec;
        logic                   last;
    } t_out;

    t_mode r_mode, n_mode;
    logic [15:0] r_cand, n_cand;
    logic [3:0]  r_wlen, n_wlen;
    logic        r_wcap, n_wcap;
    logic [LINE_BITS-1:0] r_first_line;
    logic [15:0] r_first_col;
    logic [OFFSET_BITS-1:0] r_so, r_sl, r_co, r_cl;
    logic [COLUMN_BITS-1:0] r_sc, r_cc;
    t_out r_buf [3];
    logic [1:0] r_count;
    logic [1:0] r_head;

    logic       adv, beg, rst_pos;
    t_tok       tok0, tok1;
    logic       tok0_v, tok1_v;
    logic       take, pop;
    logic [OFFSET_BITS-1:0] nx_o, nx_l, ld_l;
    logic [COLUMN_BITS-1:0] nx_c, ld_c;
    t_out       e0, e1;

    // ring position modulo three
    function automatic logic [1:0] wrap3(input logic [2:0] v);
        return (v >= 3'd3) ? 2'(v - 3'd3) : v[1:0];
    endfunction

    qll_classify u_classify (
        .i_mode(r_mode), .i_cand(r_cand), .i_wlen(r_wlen), .i_wcap(r_wcap),
        .i_byte(i_text.text_byte),
        .o_mode(n_mode), .o_cand(n_cand), .o_wlen(n_wlen), .o_wcap(n_wcap),
        .o_advance(adv), .o_begin(beg), .o_restart(rst_pos),
        .o_tok0(tok0), .o_tok0_v(tok0_v), .o_tok1(tok1), .o_tok1_v(tok1_v)
    );

    assign i_text.ready = (r_count < 2'd2) || ((r_count == 2'd2) && o_token.ready);
    assign i_cfg.ready  = 1'b1;
    assign take = i_text.valid && i_text.ready;
    assign pop  = o_token.valid && o_token.ready;

    // saturating clamp of the register values to the parameter widths
    always_comb begin
        if (OFFSET_BITS < LINE_BITS && (r_first_line >> OFFSET_BITS) != '0) ld_l = POS_MAX;
        else ld_l = OFFSET_BITS'(r_first_line);
        if (COLUMN_BITS < 16 && (r_first_col >> COLUMN_BITS) != '0) ld_c = COL_MAX;
        else ld_c = COLUMN_BITS'(r_first_col);
    end

    always_comb begin
        nx_o = (r_co == POS_MAX) ? r_co : r_co + 1'b1;
        if (i_text.text_byte == 8'h0A) begin
            nx_l = (r_cl == POS_MAX) ? r_cl : r_cl + 1'b1;
            nx_c = COLUMN_BITS'(1);
        end else begin
            nx_l = r_cl;
            nx_c = (r_cc == COL_MAX) ? r_cc : r_cc + 1'b1;
        end
        e0.kind = tok0.kind;
        e0.so = r_so; e0.sl = r_sl; e0.sc = r_sc;
        e0.eo = tok0.end_next ? nx_o : r_co;
        e0.el = tok0.end_next ? nx_l : r_cl;
        e0.ec = tok0.end_next ? nx_c : r_cc;
        e0.last = !tok1_v;
        e1.kind = tok1.kind;
        e1.so = r_co; e1.sl = r_cl; e1.sc = r_cc;
        e1.eo = tok1.end_next ? nx_o : r_co;
        e1.el = tok1.end_next ? nx_l : r_cl;
        e1.ec = tok1.end_next ? nx_c : r_cc;
        e1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        logic [1:0] cnt;
        logic [1:0] slot;
        logic [1:0] wr0, wr1;
        if (!i_rst_n) begin
            r_mode <= MD_IDLE;
            r_cand <= '1; r_wlen <= 4'd0; r_wcap <= 1'b0;
            r_first_line <= LINE_BITS'(1); r_first_col <= 16'd1;
            r_so <= '0; r_co <= '0;
            r_sl <= OFFSET_BITS'(1); r_cl <= OFFSET_BITS'(1);
            r_sc <= COLUMN_BITS'(1); r_cc <= COLUMN_BITS'(1);
            r_count <= 2'd0; r_head <= 2'd0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_FIRST_LINE) r_first_line <= i_cfg.data;
                else r_first_col <= i_cfg.data[15:0];
            end
            if (i_cfg.valid && r_mode == MD_IDLE && r_co == '0) begin
                // reload positions from the value being written
                if (i_cfg.index == REG_FIRST_LINE) begin
                    r_cl <= (OFFSET_BITS < LINE_BITS && (i_cfg.data >> OFFSET_BITS) != '0)
                        ? POS_MAX : OFFSET_BITS'(i_cfg.data);
                    r_sl <= (OFFSET_BITS < LINE_BITS && (i_cfg.data >> OFFSET_BITS) != '0)
                        ? POS_MAX : OFFSET_BITS'(i_cfg.data);
                end else begin
                    r_cc <= (COLUMN_BITS < 16 && (i_cfg.data[15:0] >> COLUMN_BITS) != '0)
                        ? COL_MAX : COLUMN_BITS'(i_cfg.data[15:0]);
                    r_sc <= (COLUMN_BITS < 16 && (i_cfg.data[15:0] >> COLUMN_BITS) != '0)
                        ? COL_MAX : COLUMN_BITS'(i_cfg.data[15:0]);
                end
                r_so <= '0;
            end
            cnt = r_count;
            slot = r_head;
            if (pop) begin
                cnt = cnt - 2'd1;
                slot = wrap3({1'b0, slot} + 3'd1);
                r_head <= slot;
            end
            wr0 = wrap3({1'b0, slot} + {1'b0, cnt});
            wr1 = wrap3({1'b0, slot} + {1'b0, cnt} + 3'd1);
            if (take) begin
                r_mode <= n_mode; r_cand <= n_cand; r_wlen <= n_wlen; r_wcap <= n_wcap;
                if (rst_pos) begin
                    r_co <= '0; r_so <= '0;
                    r_cl <= ld_l; r_sl <= ld_l;
                    r_cc <= ld_c; r_sc <= ld_c;
                end else begin
                    if (adv) begin r_co <= nx_o; r_cl <= nx_l; r_cc <= nx_c; end
                    if (beg) begin r_so <= r_co; r_sl <= r_cl; r_sc <= r_cc; end
                end
                if (tok0_v && tok1_v) begin
                    r_buf[wr0] <= e0;
                    r_buf[wr1] <= e1;
                    cnt = cnt + 2'd2;
                end else if (tok0_v) begin
                    r_buf[wr0] <= e0;
                    cnt = cnt + 2'd1;
                end else if (tok1_v) begin
                    r_buf[wr0] <= e1;
                    cnt = cnt + 2'd1;
                end
            end
            r_count <= cnt;
        end
    end

    assign o_token.valid        = r_count != 2'd0;
    assign o_token.token_kind   = r_buf[r_head].kind;
    assign o_token.start_offset = r_buf[r_head].so;
    assign o_token.start_line   = r_buf[r_head].sl;
    assign o_token.start_column = r_buf[r_head].sc;
    assign o_token.end_offset   = r_buf[r_head].eo;
    assign o_token.end_line     = r_buf[r_head].el;
    assign o_token.end_column   = r_buf[r_head].ec;
    assign o_token.last_of_run  = r_buf[r_head].last;

    `QLL_ASSERT_IMPL(a_head_range, i_clk, i_rst_n, 1'b1, r_head != 2'd3)
    `QLL_ASSERT_NEXT(a_eof_restarts, i_clk, i_rst_n, take && i_text.text_byte == 8'h00,
        r_mode == MD_IDLE && r_co == '0)
    `QLL_ASSERT_IMPL(a_take_room, i_clk, i_rst_n, take, r_count <= 2'd1 || pop)
endmodule
`default_nettype wire

FILE: rtl/qll_classify.sv
// next-state and token decision of the lexer for one byte
`default_nettype none
module qll_classify (
    input  var qll_pkg::t_mode  i_mode,
    input  wire [15:0]          i_cand,
    input  wire [3:0]           i_wlen,
    input  wire                 i_wcap,
    input  wire [7:0]           i_byte,
    output qll_pkg::t_mode      o_mode,
    output logic [15:0]         o_cand,
    output logic [3:0]          o_wlen,
    output logic                o_wcap,
    output logic                o_advance,
    output logic                o_begin,
    output logic                o_restart,
    output qll_pkg::t_tok       o_tok0,
    output logic                o_tok0_v,
    output qll_pkg::t_tok       o_tok1,
    output logic                o_tok1_v
);
    import qll_pkg::*;

    logic       c_ws, c_dig, c_up, c_head, c_tail, fresh;
    logic [15:0] take_cand, head_cand;
    logic [5:0] wkind;

    assign c_ws   = (i_byte == 8'h20) || (i_byte == 8'h0A) || (i_byte == 8'h09);
    assign c_dig  = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign c_up   = (i_byte >= 8'h41) && (i_byte <= 8'h5A);
    assign c_head = c_up || ((i_byte >= 8'h61) && (i_byte <= 8'h7A)) || (i_byte == 8'h5F);
    assign c_tail = c_head || c_dig;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            take_cand[i] = i_cand[i] && (i_wlen < kw_len(4'(i)))
                && (kw_char(4'(i), i_wlen) == i_byte);
            head_cand[i] = kw_char(4'(i), 4'd0) == i_byte;
        end
        wkind = i_wcap ? K_TYPE : K_NAME;
        for (int i = 15; i >= 0; i--) begin
            if (i_cand[i] && kw_len(4'(i)) == i_wlen) wkind = K_KW0 + 6'(i);
        end
    end

    always_comb begin
        o_mode = i_mode;
        o_cand = i_cand;
        o_wlen = i_wlen;
        o_wcap = i_wcap;
        o_advance = 1'b0;
        o_begin = 1'b0;
        o_restart = 1'b0;
        o_tok0 = '{kind: K_ERROR, start_cur: 1'b0, end_next: 1'b0};
        o_tok0_v = 1'b0;
        o_tok1 = '{kind: K_ERROR, start_cur: 1'b1, end_next: 1'b1};
        o_tok1_v = 1'b0;
        fresh = 1'b0;
        // first token: closes the pending one; end_next marks inclusion of this byte
        unique case (i_mode)
            MD_WS: if (c_ws) o_advance = 1'b1;
                   else begin o_tok0.kind = K_WS; o_tok0_v = 1'b1; fresh = 1'b1; end
            MD_LCOMMENT: if (i_byte != 8'h0A && i_byte != 8'h00) o_advance = 1'b1;
                   else begin o_tok0.kind = K_LCOMMENT; o_tok0_v = 1'b1; fresh = 1'b1; end
            MD_SLASH: if (i_byte == 8'h2F) begin o_advance = 1'b1; o_mode = MD_LCOMMENT; end
                   else if (i_byte == 8'h2A) begin o_advance = 1'b1; o_mode = MD_BLOCK; end
                   else begin o_tok0.kind = K_SLASH; o_tok0_v = 1'b1; fresh = 1'b1; end
            MD_BLOCK, MD_BLOCK_STAR: begin
                if (i_byte == 8'h00) begin
                    o_tok0.kind = K_ERROR; o_tok0_v = 1'b1; fresh = 1'b1;
                end else begin
                    o_advance = 1'b1;
                    if (i_mode == MD_BLOCK_STAR && i_byte == 8'h2F) begin
                        o_tok0.kind = K_BCOMMENT; o_tok0.end_next = 1'b1; o_tok0_v = 1'b1;
                        o_mode = MD_IDLE;
                    end else o_mode = (i_byte == 8'h2A) ? MD_BLOCK_STAR : MD_BLOCK;
                end
            end
            MD_QNAME: begin
                if (i_byte == 8'h00) begin
                    o_tok0.kind = K_ERROR; o_tok0_v = 1'b1; fresh = 1'b1;
                end else begin
                    o_advance = 1'b1;
                    if (i_byte == 8'h22) begin
                        o_tok0.kind = K_QNAME; o_tok0.end_next = 1'b1; o_tok0_v = 1'b1;
                        o_mode = MD_IDLE;
                    end else if (i_byte == 8'h5C) o_mode = MD_QNAME_ESC;
                end
            end
            MD_QNAME_ESC: if (i_byte == 8'h00) begin
                    o_tok0.kind = K_ERROR; o_tok0_v = 1'b1; fresh = 1'b1;
                end else begin o_advance = 1'b1; o_mode = MD_QNAME; end
            MD_STRING: if (i_byte == 8'h00) begin
                    o_tok0.kind = K_ERROR; o_tok0_v = 1'b1; fresh = 1'b1;
                end else begin
                    o_advance = 1'b1;
                    if (i_byte == 8'h27) o_mode = MD_STRING_QUOTE;
                end
            MD_STRING_QUOTE: if (i_byte == 8'h27) begin o_advance = 1'b1; o_mode = MD_STRING; end
                   else begin o_tok0.kind = K_STRING; o_tok0_v = 1'b1; fresh = 1'b1; end
            MD_INT: if (c_dig) o_advance = 1'b1;
                   else begin o_tok0.kind = K_INT; o_tok0_v = 1'b1; fresh = 1'b1; end
            MD_WORD: if (c_tail) begin
                    o_advance = 1'b1; o_cand = take_cand;
                    o_wlen = (i_wlen == 4'd15) ? i_wlen : i_wlen + 4'd1;
                end else begin o_tok0.kind = wkind; o_tok0_v = 1'b1; fresh = 1'b1; end
            MD_BANG, MD_LESS, MD_GREATER: begin
                o_tok0.kind = (i_mode == MD_BANG) ? K_NE : (i_mode == MD_LESS) ? K_LE : K_GE;
                o_tok0_v = 1'b1;
                if (i_byte == 8'h3D) begin
                    o_advance = 1'b1; o_tok0.end_next = 1'b1; o_mode = MD_IDLE;
                end else begin o_tok0.kind = o_tok0.kind + 6'd1; fresh = 1'b1; end
            end
            default: fresh = 1'b1;
        endcase

        if (fresh) begin
            o_begin = 1'b1;
            o_mode = MD_IDLE;
            if (i_byte == 8'h00) begin
                o_restart = 1'b1;
                o_tok1.kind = K_EOF; o_tok1.end_next = 1'b0;
                o_tok1_v = 1'b1;
                o_cand = '1; o_wlen = 4'd0; o_wcap = 1'b0;
            end else begin
                o_advance = 1'b1;
                if (c_ws) o_mode = MD_WS;
                else if (i_byte == 8'h2F) o_mode = MD_SLASH;
                else if (i_byte == 8'h22) o_mode = MD_QNAME;
                else if (i_byte == 8'h27) o_mode = MD_STRING;
                else if (c_dig) o_mode = MD_INT;
                else if (i_byte == 8'h21) o_mode = MD_BANG;
                else if (i_byte == 8'h3C) o_mode = MD_LESS;
                else if (i_byte == 8'h3E) o_mode = MD_GREATER;
                else if (c_head) begin
                    o_mode = MD_WORD; o_cand = head_cand; o_wlen = 4'd1; o_wcap = c_up;
                end else begin
                    o_tok1.kind = single_kind(i_byte); o_tok1_v = 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire
